// ===== rtl/ldrf_pkg.sv =====
// Shared types and constants for the line-drop receive FIFO.
// Holds the ring geometry, field widths, mode codes, controller state and command struct.
// No dependencies.
package ldrf_pkg;

	// Ring geometry. The ring holds at most DEPTH-1 bytes.
	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int BYTE_W = 8;
	localparam int FILL_W = 7;

	// The terminator register comes out of reset as a line feed.
	localparam logic [BYTE_W-1:0] TERM_RESET = 8'h0a;

	// Item modes.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RESP = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;     // Perform the accepted push or pop.
		logic respond;  // Present the result for one cycle.
	} cmd_t;

endpackage

// ===== rtl/ldrf_ctrl.sv =====
// Controller for the line-drop receive FIFO.
// Sequences one item at a time: execute on acceptance, then one result cycle.
// Depends on ldrf_pkg.
module ldrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output ldrf_pkg::cmd_t cmd
);

	ldrf_pkg::state_t state_q;
	ldrf_pkg::state_t state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ldrf_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ldrf_pkg::ST_RESP;
				end
			end
			ldrf_pkg::ST_RESP: begin
				state_d = ldrf_pkg::ST_IDLE;
			end
			default: begin
				state_d = ldrf_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The block is busy in every state except idle.
	assign busy        = (state_q != ldrf_pkg::ST_IDLE);
	assign cmd.exec    = (state_q == ldrf_pkg::ST_IDLE) && start;
	assign cmd.respond = (state_q == ldrf_pkg::ST_RESP);

endmodule

// ===== rtl/ldrf_datapath.sv =====
// Datapath for the line-drop receive FIFO.
// Holds the byte ring, its indices, the overflow flag, the terminator and the result registers.
// Depends on ldrf_pkg.
module ldrf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ldrf_pkg::cmd_t                cmd,
	input  logic                          mode,
	input  logic [ldrf_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          cfg_wr,
	input  logic [ldrf_pkg::BYTE_W-1:0]   cfg_data,
	output logic                          stored,
	output logic                          in_overflow,
	output logic                          read_valid,
	output logic [ldrf_pkg::BYTE_W-1:0]   read_byte,
	output logic [ldrf_pkg::FILL_W-1:0]   fill_level
);

	localparam logic [ldrf_pkg::IDX_W-1:0] LAST_IDX = ldrf_pkg::IDX_W'(ldrf_pkg::DEPTH - 1);
	localparam logic [ldrf_pkg::IDX_W:0]   DEPTH_W  = (ldrf_pkg::IDX_W+1)'(ldrf_pkg::DEPTH);

	logic [ldrf_pkg::BYTE_W-1:0] mem_q [ldrf_pkg::DEPTH];
	logic [ldrf_pkg::BYTE_W-1:0] rdata_q;
	logic [ldrf_pkg::BYTE_W-1:0] term_q;
	logic [ldrf_pkg::IDX_W-1:0]  wr_idx_q;
	logic [ldrf_pkg::IDX_W-1:0]  rd_idx_q;
	logic                        ovf_q;
	logic                        stored_q;
	logic                        valid_q;

	logic [ldrf_pkg::IDX_W-1:0]  wr_next;
	logic [ldrf_pkg::IDX_W-1:0]  rd_next;
	logic                        full;
	logic                        empty;
	logic                        do_push;
	logic                        do_write;
	logic                        do_pop;
	logic                        ovf_d;
	logic [ldrf_pkg::IDX_W:0]    count;

	// Ring index arithmetic and occupancy.
	assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign full    = (wr_next == rd_idx_q);
	assign empty   = (wr_idx_q == rd_idx_q);

	// Push policy: once overflowed, only a terminator that finds room is stored.
	always_comb begin
		do_push  = cmd.exec && (mode == ldrf_pkg::MODE_PUSH);
		do_pop   = cmd.exec && (mode == ldrf_pkg::MODE_POP) && !empty;
		do_write = 1'b0;
		ovf_d    = ovf_q;
		if (do_push) begin
			if (!ovf_q) begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					do_write = 1'b1;
				end
			end else if ((rx_byte == term_q) && !full) begin
				do_write = 1'b1;
				ovf_d    = 1'b0;
			end
		end
	end

	// Byte ring with a registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[wr_idx_q] <= rx_byte;
		end
		if (do_pop) begin
			rdata_q <= mem_q[rd_idx_q];
		end
	end

	// Indices, flag, terminator and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			ovf_q    <= 1'b0;
			term_q   <= ldrf_pkg::TERM_RESET;
			stored_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				term_q <= cfg_data;
			end
			if (cmd.exec) begin
				stored_q <= do_write;
				valid_q  <= do_pop;
				ovf_q    <= ovf_d;
			end
			if (do_write) begin
				wr_idx_q <= wr_next;
			end
			if (do_pop) begin
				rd_idx_q <= rd_next;
			end
		end
	end

	// Occupancy after the last item, shown as its low bits.
	always_comb begin
		if (wr_idx_q >= rd_idx_q) begin
			count = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		end else begin
			count = {1'b0, wr_idx_q} + DEPTH_W - {1'b0, rd_idx_q};
		end
	end

	// Result fields are meaningful while the respond command is high.
	assign stored      = stored_q;
	assign in_overflow = ovf_q;
	assign read_valid  = valid_q;
	assign read_byte   = valid_q ? rdata_q : '0;
	assign fill_level  = count[ldrf_pkg::FILL_W-1:0];

endmodule

// ===== rtl/line_drop_receive_fifo_unit.sv =====
// Top level of the line-drop receive FIFO.
// Joins the controller and the datapath; depends on ldrf_pkg, ldrf_ctrl and ldrf_datapath.
//
// Each item is accepted at an edge where start is high and busy is low, the push or pop
// is carried out at that edge against the byte ring, and the result is shown for the
// following cycle with done high, after which busy drops again. The result waits on the
// registered read port of the ring, which delivers a popped byte in the cycle after
// the item is accepted. The result is held for exactly one cycle and the
// receiver cannot stall it, so it must take every transfer marked by done. The ring holds
// at most 127 bytes; a push into a full ring sets the overflow flag, and from then on every
// byte except the terminator is discarded until a terminator finds room. The terminator
// register is always ready and should be written only while the block is idle.
module line_drop_receive_fifo_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [ldrf_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ldrf_pkg::BYTE_W-1:0]   cfg_data,
	output logic                          done,
	output logic                          stored,
	output logic                          in_overflow,
	output logic                          read_valid,
	output logic [ldrf_pkg::BYTE_W-1:0]   read_byte,
	output logic [ldrf_pkg::FILL_W-1:0]   fill_level
);

	ldrf_pkg::cmd_t cmd;

	// Sequencing.
	ldrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Ring storage and result registers.
	ldrf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.rx_byte     (rx_byte),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.stored      (stored),
		.in_overflow (in_overflow),
		.read_valid  (read_valid),
		.read_byte   (read_byte),
		.fill_level  (fill_level)
	);

	// A configuration transfer completes in any cycle.
	assign cfg_ready = 1'b1;
	assign done      = cmd.respond;

endmodule
